// ===== rtl/mjpeg_multipart_frame_extractor_core_assert.svh =====
// Assertion macros used by the checker file of the frame extractor.
`ifndef MJPEG_MULTIPART_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define MJPEG_MULTIPART_FRAME_EXTRACTOR_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define MMFE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MMFE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mmfe_pkg
// Shared types and constants of the multipart MJPEG frame extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmfe_pkg;

   localparam int WIN_DEPTH    = 15;
   localparam int FILL_W       = 4;
   localparam int BOUNDARY_LEN = 12;
   localparam int MARKER_LEN   = 14;
   localparam int HDR_END_LEN  = 4;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   // CR LF "--myboundary"; its last twelve bytes are the boundary itself
   localparam logic [0:MARKER_LEN-1][7:0] MARKER_PAT = '{
      CHAR_CR, CHAR_LF, 8'h2d, 8'h2d, 8'h6d, 8'h79, 8'h62,
      8'h6f, 8'h75, 8'h6e, 8'h64, 8'h61, 8'h72, 8'h79
   };

   localparam logic [0:HDR_END_LEN-1][7:0] HDR_END_PAT = '{
      CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF
   };

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_last;
      logic       frame_empty;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/mmfe_parser.sv =====
// ----------------------------------------------------------------------------
// mmfe_parser
// Front end: tracks the multipart stream mode and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmfe_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [7:0]        data_byte,
   input  wire logic              restart,
   output mmfe_pkg::push_type     push
);

   typedef enum logic [2:0] {
      MODE_HUNT    = 3'b001,
      MODE_HEADER  = 3'b010,
      MODE_PAYLOAD = 3'b100
   } mode_type;

   localparam int FW = mmfe_pkg::FILL_W;

   mode_type                                   mode_ff, mode_in;
   logic [FW-1:0]                              fill_ff, fill_in;
   logic [mmfe_pkg::WIN_DEPTH-1:0][7:0]        window_ff, window_in;

   logic [mmfe_pkg::WIN_DEPTH-1:0][7:0]        win_new;
   logic [FW-1:0]                              cnt_new;
   logic                                       marker_eq, boundary_eq, hdr_eq;
   logic                                       marker_ok, boundary_ok, hdr_ok, full;

   // window index 0 holds the newest byte
   always_comb begin
      win_new = {window_ff[mmfe_pkg::WIN_DEPTH-2:0], data_byte};
      cnt_new = (fill_ff == FW'(mmfe_pkg::WIN_DEPTH)) ? fill_ff : fill_ff + 1'b1;

      marker_eq   = 1'b1;
      boundary_eq = 1'b1;
      hdr_eq      = 1'b1;
      for (int i = 0; i < mmfe_pkg::MARKER_LEN; i++) begin
         if (win_new[i] != mmfe_pkg::MARKER_PAT[mmfe_pkg::MARKER_LEN-1-i]) begin
            marker_eq = 1'b0;
            if (i < mmfe_pkg::BOUNDARY_LEN) begin
               boundary_eq = 1'b0;
            end
         end
      end
      for (int i = 0; i < mmfe_pkg::HDR_END_LEN; i++) begin
         if (win_new[i] != mmfe_pkg::HDR_END_PAT[mmfe_pkg::HDR_END_LEN-1-i]) begin
            hdr_eq = 1'b0;
         end
      end

      marker_ok   = marker_eq && (cnt_new >= FW'(mmfe_pkg::MARKER_LEN));
      boundary_ok = boundary_eq && (cnt_new >= FW'(mmfe_pkg::BOUNDARY_LEN));
      hdr_ok      = hdr_eq && (cnt_new >= FW'(mmfe_pkg::HDR_END_LEN));
      full        = (cnt_new == FW'(mmfe_pkg::WIN_DEPTH));
   end

   always_comb begin
      mode_in   = mode_ff;
      fill_in   = fill_ff;
      window_in = window_ff;
      push      = '0;
      if (take) begin
         if (restart) begin
            mode_in = MODE_HUNT;
            fill_in = '0;
         end else begin
            window_in = win_new;
            fill_in   = cnt_new;
            case (mode_ff)
               MODE_HEADER: begin
                  if (hdr_ok) begin
                     fill_in = '0;
                     mode_in = MODE_PAYLOAD;
                  end
               end
               MODE_PAYLOAD: begin
                  if (marker_ok) begin
                     // close the frame; the marker's boundary opens the next part
                     push.valid             = 1'b1;
                     push.item.payload_byte = full ? win_new[mmfe_pkg::WIN_DEPTH-1] : 8'h00;
                     push.item.frame_last   = 1'b1;
                     push.item.frame_empty  = !full;
                     fill_in                = '0;
                     mode_in                = MODE_HEADER;
                  end else if (full) begin
                     // release the oldest held byte
                     push.valid             = 1'b1;
                     push.item.payload_byte = win_new[mmfe_pkg::WIN_DEPTH-1];
                  end
               end
               default: begin
                  mode_in = MODE_HUNT;
                  if (boundary_ok) begin
                     fill_in = '0;
                     mode_in = MODE_HEADER;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HUNT;
         fill_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

`default_nettype wire

// ===== rtl/mmfe_queue.sv =====
// ----------------------------------------------------------------------------
// mmfe_queue
// Back end: short result queue that drives the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmfe_queue #(
   parameter int Depth = mmfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mmfe_pkg::push_type     push,
   output logic                        space,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_payload_byte,
   output logic                        rsp_frame_last,
   output logic                        rsp_frame_empty
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   mmfe_pkg::rsp_item_type   mem_ff [Depth];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     do_push, do_pop;

   assign space     = (count_ff != CNT_W'(Depth));
   assign rsp_valid = (count_ff != '0);
   assign do_push   = push.valid;
   assign do_pop    = rsp_valid && rsp_ready;

   assign rsp_payload_byte = mem_ff[rd_ptr_ff].payload_byte;
   assign rsp_frame_last   = mem_ff[rd_ptr_ff].frame_last;
   assign rsp_frame_empty  = mem_ff[rd_ptr_ff].frame_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mjpeg_multipart_frame_extractor_core.sv =====
// A result word is written into the registered result queue when the byte that caused it is taken.
// Throughput: one byte per cycle while the queue has space; the parser's window compare is combinational.
// The result queue (QUEUE_DEPTH words) stalls req_ready only when it is full.
// Reset (synchronous, active high) returns to boundary hunt and empties the queue;
// it needs no clearing pass.
// ----------------------------------------------------------------------------
// mjpeg_multipart_frame_extractor_core
// Cuts JPEG frames out of a multipart MJPEG HTTP byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mjpeg_multipart_frame_extractor_core #(
   parameter int QUEUE_DEPTH = mmfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_frame_last,
   output logic             rsp_frame_empty
);

   mmfe_pkg::push_type push;
   logic               space;

   assign req_ready = space;

   mmfe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (req_valid && space),
      .data_byte (req_data_byte),
      .restart   (req_restart),
      .push      (push)
   );

   mmfe_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .space            (space),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_empty  (rsp_frame_empty)
   );

endmodule

`default_nettype wire

// ===== rtl/mmfe_checker.sv =====
// ----------------------------------------------------------------------------
// mmfe_checker
// Port-level checks of the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mjpeg_multipart_frame_extractor_core_assert.svh"

module mmfe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_restart,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_frame_last,
   input wire logic       rsp_frame_empty
);

   logic       req_stall, rsp_stall;
   logic [8:0] req_word;
   logic [9:0] rsp_word;

   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_word  = {req_restart, req_data_byte};
   assign rsp_word  = {rsp_payload_byte, rsp_frame_last, rsp_frame_empty};

   // hold a stalled word
   `MMFE_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled rsp changed")

   `MMFE_ASSERT(a_req_hold, clock, reset, req_stall |=> req_valid && $stable(req_word), "stalled req changed")

   `MMFE_ASSERT(a_empty_form, clock, reset, rsp_valid && rsp_frame_empty |-> rsp_frame_last && rsp_payload_byte == 8'h00, "empty frame word malformed")

   `MMFE_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> req_ready && !rsp_valid, "queue not empty after reset")

endmodule

bind mjpeg_multipart_frame_extractor_core mmfe_checker u_mmfe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_data_byte    (req_data_byte),
   .req_restart      (req_restart),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_last   (rsp_frame_last),
   .rsp_frame_empty  (rsp_frame_empty)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multipart MJPEG frame extractor. It feeds byte
// streams that hold boundaries, headers, frames of many lengths, empty frames,
// near-miss closing markers and restarts. Both handshakes pause at random. A
// scoreboard tracks the parser state and checks every result word in order.
// ----------------------------------------------------------------------------

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 580;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_SHOWN    = 10;

   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_HEADER  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } parse_mode_type;

   class frame_scoreboard;
      logic [7:0]                             hold_win [mmfe_pkg::WIN_DEPTH];
      int                                     hold_fill;
      parse_mode_type                         mode;
      logic [0:mmfe_pkg::MARKER_LEN-1][7:0]   hdr_end_tail;
      mmfe_pkg::rsp_item_type                 expected_words [$];
      int                                     errors;

      function new();
         // right-align the header end so one tail compare serves every pattern
         hdr_end_tail = '0;
         for (int i = 0; i < mmfe_pkg::HDR_END_LEN; i++)
            hdr_end_tail[mmfe_pkg::MARKER_LEN - mmfe_pkg::HDR_END_LEN + i] =
               mmfe_pkg::HDR_END_PAT[i];
         clear_window();
         mode   = MODE_HUNT;
         errors = 0;
      endfunction

      function void clear_window();
         for (int i = 0; i < mmfe_pkg::WIN_DEPTH; i++) hold_win[i] = 8'h00;
         hold_fill = 0;
      endfunction

      function void push_byte(logic [7:0] b, int depth);
         if (hold_fill < depth) begin
            hold_win[hold_fill] = b;
            hold_fill++;
         end else begin
            for (int i = 0; i < depth - 1; i++) hold_win[i] = hold_win[i + 1];
            hold_win[depth - 1] = b;
         end
      endfunction

      // last len bytes held against the last len bytes of pat
      function bit tail_is(logic [0:mmfe_pkg::MARKER_LEN-1][7:0] pat, int len);
         if (hold_fill < len) return 1'b0;
         for (int i = 0; i < len; i++)
            if (hold_win[hold_fill - len + i] != pat[mmfe_pkg::MARKER_LEN - len + i])
               return 1'b0;
         return 1'b1;
      endfunction

      function void note_byte(logic [7:0] b, logic restart);
         mmfe_pkg::rsp_item_type w;
         if (restart) begin
            clear_window();
            mode = MODE_HUNT;
         end else if (mode == MODE_HEADER) begin
            push_byte(b, mmfe_pkg::HDR_END_LEN);
            if (tail_is(hdr_end_tail, mmfe_pkg::HDR_END_LEN)) begin
               clear_window();
               mode = MODE_PAYLOAD;
            end
         end else if (mode == MODE_PAYLOAD) begin
            push_byte(b, mmfe_pkg::WIN_DEPTH);
            if (tail_is(mmfe_pkg::MARKER_PAT, mmfe_pkg::MARKER_LEN)) begin
               w.payload_byte = (hold_fill == mmfe_pkg::WIN_DEPTH) ? hold_win[0] : 8'h00;
               w.frame_last   = 1'b1;
               w.frame_empty  = (hold_fill != mmfe_pkg::WIN_DEPTH);
               expected_words.push_back(w);
               clear_window();
               mode = MODE_HEADER;
            end else if (hold_fill == mmfe_pkg::WIN_DEPTH) begin
               w.payload_byte = hold_win[0];
               w.frame_last   = 1'b0;
               w.frame_empty  = 1'b0;
               expected_words.push_back(w);
               for (int i = 0; i < mmfe_pkg::WIN_DEPTH - 1; i++) hold_win[i] = hold_win[i + 1];
               hold_win[mmfe_pkg::WIN_DEPTH - 1] = 8'h00;
               hold_fill = mmfe_pkg::WIN_DEPTH - 1;
            end
         end else begin
            mode = MODE_HUNT;
            push_byte(b, mmfe_pkg::BOUNDARY_LEN);
            if (tail_is(mmfe_pkg::MARKER_PAT, mmfe_pkg::BOUNDARY_LEN)) begin
               clear_window();
               mode = MODE_HEADER;
            end
         end
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= MAX_SHOWN) $display("%0t: %s", $time, msg);
      endfunction

      function void check_word(logic [7:0] p, logic l, logic e);
         mmfe_pkg::rsp_item_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word: byte %02h last %0b empty %0b", p, l, e));
            return;
         end
         want = expected_words.pop_front();
         if (want.payload_byte !== p || want.frame_last !== l || want.frame_empty !== e)
            report($sformatf({"word mismatch: expected byte %02h last %0b empty %0b,",
                              " got byte %02h last %0b empty %0b"},
                             want.payload_byte, want.frame_last, want.frame_empty,
                             p, l, e));
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void flag_leftovers();
         if (expected_words.size() != 0)
            report($sformatf("%0d expected words never arrived", expected_words.size()));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_restart;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_payload_byte;
   logic       rsp_frame_last;
   logic       rsp_frame_empty;

   frame_scoreboard sb;
   logic [8:0]      stream_q [$];   // {restart, data_byte}
   bit              calm;
   int              cycle_count;

   mjpeg_multipart_frame_extractor_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_empty  (rsp_frame_empty)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void add_word(logic [7:0] b, logic restart = 1'b0);
      stream_q.push_back({restart, b});
   endfunction

   function automatic void add_boundary();
      for (int i = mmfe_pkg::MARKER_LEN - mmfe_pkg::BOUNDARY_LEN; i < mmfe_pkg::MARKER_LEN; i++)
         add_word(mmfe_pkg::MARKER_PAT[i]);
   endfunction

   function automatic void add_marker();
      for (int i = 0; i < mmfe_pkg::MARKER_LEN; i++) add_word(mmfe_pkg::MARKER_PAT[i]);
   endfunction

   function automatic void add_header_end();
      for (int i = 0; i < mmfe_pkg::HDR_END_LEN; i++) add_word(mmfe_pkg::HDR_END_PAT[i]);
   endfunction

   // printable header lines, now and then a boundary that must be ignored
   function automatic void add_header();
      int n;
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0: begin
               add_word(mmfe_pkg::CHAR_CR);
               add_word(mmfe_pkg::CHAR_LF);
               add_word(8'($urandom_range(8'h20, 8'h7e)));
            end
            1: add_boundary();
            default: add_word(8'($urandom_range(8'h20, 8'h7e)));
         endcase
      end
      add_header_end();
   endfunction

   function automatic void add_payload(int n);
      int         k;
      int         cut;
      logic [7:0] b;
      k = 0;
      while (k < n) begin
         if ($urandom_range(0, 19) == 0) begin
            // partial closing marker, broken by a byte that cannot continue it
            cut = $urandom_range(1, mmfe_pkg::MARKER_LEN - 1);
            for (int i = 0; i < cut; i++) add_word(mmfe_pkg::MARKER_PAT[i]);
            b = 8'($urandom_range(0, 255));
            if (b == mmfe_pkg::MARKER_PAT[cut]) b = ~b;
            add_word(b);
            k += cut + 1;
         end else begin
            case ($urandom_range(0, 9))
               0: add_word(mmfe_pkg::CHAR_CR);
               1: add_word(mmfe_pkg::CHAR_LF);
               2: add_word(mmfe_pkg::MARKER_PAT[2]);
               default: add_word(8'($urandom_range(0, 255)));
            endcase
            k++;
         end
      end
   endfunction

   function automatic int frame_len();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return 1;
         2: return $urandom_range(13, 16);
         3: return $urandom_range(40, 60);
         default: return $urandom_range(2, 20);
      endcase
   endfunction

   task automatic send_word(logic [8:0] w);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_restart   <= w[8];
      req_data_byte <= w[7:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(w[7:0], w[8]);
      @(negedge clock);
   endtask

   // hold the sender until every expected word has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_payload_byte, rsp_frame_last, rsp_frame_empty);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int directed_n;
      int calm_from;
      int pick;
      int cut;
      int b_off;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_restart   = 1'b0;
      calm          = 1'b0;
      cycle_count   = 0;
      b_off         = mmfe_pkg::MARKER_LEN - mmfe_pkg::BOUNDARY_LEN;
      sb = new();

      // restart with junk data, then the shortest part: boundary, header end, empty frame
      add_word(8'hff, 1'b1);
      add_boundary();
      add_header_end();
      add_marker();
      directed_n = stream_q.size();

      while (stream_q.size() < directed_n + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            repeat ($urandom_range(0, 4)) add_word(8'($urandom_range(0, 255)));
            add_boundary();
            repeat ($urandom_range(1, 4)) begin
               add_header();
               add_payload(frame_len());
               add_marker();
            end
         end else if (pick == 7) begin
            // drop a frame halfway with a restart
            add_boundary();
            add_header();
            add_payload($urandom_range(0, 20));
            add_word(8'($urandom_range(0, 255)), 1'b1);
         end else if (pick == 8) begin
            cut = $urandom_range(1, mmfe_pkg::BOUNDARY_LEN - 1);
            for (int i = 0; i < cut; i++) add_word(mmfe_pkg::MARKER_PAT[b_off + i]);
            if ($urandom_range(0, 1) == 0) begin
               add_word(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               for (int i = cut; i < mmfe_pkg::BOUNDARY_LEN; i++)
                  add_word(mmfe_pkg::MARKER_PAT[b_off + i]);
               repeat ($urandom_range(0, 6)) add_word(8'($urandom_range(0, 255)));
               add_word(8'($urandom_range(0, 255)), 1'b1);
            end
         end else begin
            repeat ($urandom_range(1, 10))
               add_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end
      calm_from = stream_q.size() - stream_q.size() / 8;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stream_q[i]) begin
         if (i == directed_n || i == stream_q.size() / 2) drain_results();
         if (i >= calm_from) calm = 1'b1;
         send_word(stream_q[i]);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mmfe_pkg.sv
rtl/mmfe_parser.sv
rtl/mmfe_queue.sv
rtl/mjpeg_multipart_frame_extractor_core.sv
rtl/mmfe_checker.sv
sim/tb.sv
